### sv/spn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPN cipher package
// Field widths, register indexes, S-box tables and the round helper functions
// shared by the cipher core and the top level.
// ----------------------------------------------------------------------------
package spn_pkg;

	localparam int BLOCK_W = 16;
	localparam int KEY_W = 32;
	localparam int NIBBLES = BLOCK_W / 4;
	localparam int ROUNDS = 4;
	localparam int CFG_IDX_W = 2;

	typedef logic [BLOCK_W-1:0] block_t;
	typedef logic [KEY_W-1:0] key_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_CIPHER_KEY = 2'd0;
	localparam cfg_idx_t REG_DECRYPT_MODE = 2'd1;
	localparam cfg_idx_t REG_CHAIN_ENABLE = 2'd2;
	localparam cfg_idx_t REG_INIT_VECTOR = 2'd3;

	localparam logic [3:0] SBOX_FWD [16] = '{
		4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
		4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
	};
	localparam logic [3:0] SBOX_INV [16] = '{
		4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
		4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
	};
	// Bit positions counted from the most significant bit.
	localparam logic [3:0] BIT_PERM [16] = '{
		4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
		4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15
	};

	function automatic block_t subst_fwd(block_t x);
		block_t y;
		for (int n = 0; n < NIBBLES; n++) begin
			y[4*n +: 4] = SBOX_FWD[x[4*n +: 4]];
		end
		return y;
	endfunction

	function automatic block_t subst_inv(block_t x);
		block_t y;
		for (int n = 0; n < NIBBLES; n++) begin
			y[4*n +: 4] = SBOX_INV[x[4*n +: 4]];
		end
		return y;
	endfunction

	// Output bit i (from the top) takes input bit BIT_PERM[i]; the transpose is
	// its own inverse.
	function automatic block_t permute(block_t x);
		block_t y;
		for (int i = 0; i < BLOCK_W; i++) begin
			y[BLOCK_W-1-i] = x[BLOCK_W-1-int'(BIT_PERM[i])];
		end
		return y;
	endfunction

endpackage

### sv/spn_block_cipher_cbc_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPN block cipher with CBC chaining
// Encrypts or decrypts 16-bit blocks with a four-round substitution-permutation
// network, optionally chained in CBC mode from a programmable IV.
// ----------------------------------------------------------------------------
// Usage:
// Blocks enter on the s_* stream channel: s_tdata carries the block and s_tuser
// flags the first block of a message, which chains from the IV. Results leave
// on the m_* channel, one block per input block, in order.
// The key, direction, chaining enable and IV are written through cfg_we,
// cfg_index and cfg_data while no transaction is in flight.
// A block taken into the input register passes the full cipher from that
// register and is captured in the output register, which drives m_tdata.
// Throughput is one block per clock while the receiver does not stall; the
// chaining value is updated in the same cycle the result is registered, so the
// CBC feedback loop is a single pass through the four rounds.
// When the receiver stalls, the output register holds its block and the input
// register can still take one more block; after that s_tready falls.
// Reset clears both valid flags and the chaining value, sets the key, IV and
// direction to zero (encrypt) and turns chaining on.
// ----------------------------------------------------------------------------
module spn_block_cipher_cbc_unit import spn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [BLOCK_W-1:0]   s_tdata,   // [15:0] block_in
	input  logic                 s_tuser,   // [0] chain_start
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [BLOCK_W-1:0]   m_tdata,   // [15:0] block_out
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]     cfg_data
);

	key_t   key_q;
	logic   decrypt_q;
	logic   chain_en_q;
	block_t iv_q;
	block_t chain_q;

	logic   valid_s1;
	block_t blk_s1;
	logic   start_s1;

	logic   out_valid_q;
	block_t out_data_q;

	logic   advance;
	block_t mask;
	block_t core_in;
	block_t core_out;
	block_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			decrypt_q <= 1'b0;
			chain_en_q <= 1'b1;
			iv_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CIPHER_KEY:   key_q <= cfg_data;
				REG_DECRYPT_MODE: decrypt_q <= cfg_data[0];
				REG_CHAIN_ENABLE: chain_en_q <= cfg_data[0];
				REG_INIT_VECTOR:  iv_q <= cfg_data[BLOCK_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			blk_s1 <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// The chaining value comes from the IV on a message start, otherwise from
	// the previous ciphertext block.
	assign mask = chain_en_q ? (start_s1 ? iv_q : chain_q) : '0;
	assign core_in = decrypt_q ? blk_s1 : (blk_s1 ^ mask);

	spn_core u_core (
		.block_in   (core_in),
		.cipher_key (key_q),
		.decrypt    (decrypt_q),
		.block_out  (core_out)
	);

	assign result = decrypt_q ? (core_out ^ mask) : core_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				chain_q <= decrypt_q ? blk_s1 : result;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

endmodule

### sv/spn_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPN cipher core
// Combinational four-round encryption or decryption of one 16-bit block with
// round keys taken as sliding 16-bit windows of the 32-bit key.
// ----------------------------------------------------------------------------
module spn_core import spn_pkg::*; (
	input  block_t block_in,
	input  key_t   cipher_key,
	input  logic   decrypt,
	output block_t block_out
);

	block_t rk [ROUNDS+1];
	block_t enc_w;
	block_t dec_w;

	always_comb begin
		for (int r = 0; r <= ROUNDS; r++) begin
			rk[r] = cipher_key[KEY_W-1-4*r -: BLOCK_W];
		end
	end

	always_comb begin
		enc_w = block_in;
		for (int r = 0; r < ROUNDS - 1; r++) begin
			enc_w = permute(subst_fwd(enc_w ^ rk[r]));
		end
		enc_w = subst_fwd(enc_w ^ rk[ROUNDS-1]) ^ rk[ROUNDS];
	end

	always_comb begin
		dec_w = subst_inv(block_in ^ rk[ROUNDS]) ^ rk[ROUNDS-1];
		for (int r = ROUNDS - 2; r >= 0; r--) begin
			dec_w = subst_inv(permute(dec_w)) ^ rk[r];
		end
	end

	assign block_out = decrypt ? dec_w : enc_w;

endmodule

### test/spn_block_cipher_cbc_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPN block cipher CBC unit testbench
// Streams 16-bit blocks through the cipher under a range of keys, directions,
// chaining settings and IVs. A scoreboard computes each expected block as the
// input transaction is accepted and compares it with every output transaction,
// in order, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module spn_block_cipher_cbc_unit_tb;
	import spn_pkg::*;

	// Nibble v of each table sits at bits [4*v +: 4].
	localparam logic [63:0] ENC_SBOX = 64'h7095C6A38BF21D4E;
	localparam logic [63:0] DEC_SBOX = 64'h502B69D7FAC1843E;

	class cbc_scoreboard;
		key_t key;
		bit decrypt;
		bit chain_on;
		block_t iv;
		block_t last_cipher;
		block_t expected_blocks[$];
		int errors;

		function new();
			key = '0;
			decrypt = 1'b0;
			chain_on = 1'b1;
			iv = '0;
			last_cipher = '0;
			errors = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, key_t value);
			case (idx)
				REG_CIPHER_KEY: key = value;
				REG_DECRYPT_MODE: decrypt = value[0];
				REG_CHAIN_ENABLE: chain_on = value[0];
				REG_INIT_VECTOR: iv = value[15:0];
				default: ;
			endcase
		endfunction

		function block_t sub_nibbles(block_t x, bit inv);
			block_t y;
			logic [63:0] box;
			box = inv ? DEC_SBOX : ENC_SBOX;
			for (int n = 0; n < 4; n++) begin
				y[4*n +: 4] = box[4*x[4*n +: 4] +: 4];
			end
			return y;
		endfunction

		// Transposes the block seen as a 4x4 bit matrix, rows counted from the top.
		function block_t transpose(block_t x);
			block_t y;
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					y[15-(4*r+c)] = x[15-(4*c+r)];
				end
			end
			return y;
		endfunction

		function block_t round_key(int r);
			return block_t'(key >> (16 - 4*r));
		endfunction

		function block_t encipher(block_t x);
			block_t w;
			w = x;
			for (int r = 0; r < 3; r++) begin
				w = transpose(sub_nibbles(w ^ round_key(r), 1'b0));
			end
			return sub_nibbles(w ^ round_key(3), 1'b0) ^ round_key(4);
		endfunction

		function block_t decipher(block_t x);
			block_t w;
			w = sub_nibbles(x ^ round_key(4), 1'b1) ^ round_key(3);
			for (int r = 2; r >= 0; r--) begin
				w = sub_nibbles(transpose(w), 1'b1) ^ round_key(r);
			end
			return w;
		endfunction

		function void note_block(block_t blk, bit start);
			block_t mask;
			block_t res;
			mask = chain_on ? (start ? iv : last_cipher) : '0;
			if (decrypt) begin
				res = decipher(blk) ^ mask;
				last_cipher = blk;
			end else begin
				res = encipher(blk ^ mask);
				last_cipher = res;
			end
			expected_blocks.push_back(res);
		endfunction

		function void check_block(block_t got);
			block_t exp_blk;
			if (expected_blocks.size() == 0) begin
				$display("%0t: unexpected block_out transaction: expected none, actual %h",
					$time, got);
				errors++;
				return;
			end
			exp_blk = expected_blocks.pop_front();
			if (got !== exp_blk) begin
				$display("%0t: block_out mismatch: expected %h, actual %h",
					$time, exp_blk, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_blocks.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [BLOCK_W-1:0] s_tdata = '0;   // [15:0] block_in
	logic s_tuser = 1'b0;               // [0] chain_start
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [BLOCK_W-1:0] m_tdata;        // [15:0] block_out
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [KEY_W-1:0] cfg_data = '0;

	cbc_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	spn_block_cipher_cbc_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic bit roll(int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			sb.note_block(s_tdata, s_tuser);
		end
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_block(m_tdata);
		end
	end

	// The receiver either serves a long hold-off or stalls at random.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !roll(recv_stall_pct);
			end
		end
	end

	task automatic send_block(input block_t blk, input bit start);
		@(negedge clk);
		while (roll(send_idle_pct)) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= blk;
		s_tuser <= start;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input key_t value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.set_reg(idx, value);
	endtask

	// One-bit registers get random upper bits, which the block must ignore.
	task automatic configure(input key_t key, input bit dec, input bit chain,
			input block_t iv);
		key_t junk;
		junk = $urandom();
		write_reg(REG_CIPHER_KEY, key);
		write_reg(REG_DECRYPT_MODE, {junk[31:1], dec});
		junk = $urandom();
		write_reg(REG_CHAIN_ENABLE, {junk[31:1], chain});
		write_reg(REG_INIT_VECTOR, {16'h0, iv});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic block_t pick_block();
		case ($urandom_range(19, 0))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return block_t'($urandom());
		endcase
	endfunction

	function automatic key_t pick_key();
		case ($urandom_range(9, 0))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// Mostly well-formed messages that open with a start flag; some carry
	// random start flags as noise.
	task automatic random_phase(input int n_items, input int s_pct, input int r_pct);
		int sent;
		int len;
		bit noisy;
		sent = 0;
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		while (sent < n_items) begin
			len = roll(10) ? $urandom_range(40, 13) : $urandom_range(8, 1);
			noisy = roll(12);
			for (int i = 0; i < len; i++) begin
				send_block(pick_block(), noisy ? 1'($urandom_range(1, 0)) : (i == 0));
				sent++;
			end
			if (roll(4)) begin
				wait_drain();
			end
		end
		wait_drain();
	endtask

	initial begin
		int waited;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings; the first blocks chain from the cleared chaining value.
		send_block(16'h0000, 1'b0);
		send_block(16'hFFFF, 1'b0);
		send_block(16'h1234, 1'b1);
		wait_drain();

		configure(32'hFFFF_FFFF, 1'b0, 1'b1, 16'hFFFF);
		send_block(16'hFFFF, 1'b1);
		send_block(16'h0000, 1'b0);
		send_block(16'h8001, 1'b0);
		wait_drain();

		configure(32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF);
		send_block(16'hFFFF, 1'b1);
		send_block(16'h0000, 1'b0);
		send_block(16'h0001, 1'b0);
		wait_drain();

		configure(32'h0000_0000, 1'b0, 1'b0, 16'h0000);
		send_block(16'h0000, 1'b1);
		send_block(16'hFFFF, 1'b0);
		wait_drain();
		// Turning chaining on mid-message continues from the last ciphertext.
		configure(32'h0000_0000, 1'b0, 1'b1, 16'hA5A5);
		send_block(16'h5555, 1'b0);
		wait_drain();

		configure(32'h1357_9BDF, 1'b1, 1'b0, 16'h0F0F);
		send_block(16'hAAAA, 1'b0);
		send_block(16'h8000, 1'b1);
		wait_drain();

		// Long receiver hold-off while the sender keeps offering a message.
		configure(pick_key(), 1'b0, 1'b1, block_t'($urandom()));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 60;
		for (int i = 0; i < 24; i++) begin
			send_block(pick_block(), i == 0);
		end
		wait_drain();

		for (int p = 0; p < 8; p++) begin
			configure(pick_key(), 1'($urandom_range(1, 0)), !roll(25),
				roll(10) ? 16'hFFFF : block_t'($urandom()));
			case (p % 4)
				0: random_phase(225, 0, 0);
				1: random_phase(225, 83, 0);
				2: random_phase(225, 0, 83);
				default: random_phase(225, 10, 10);
			endcase
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		waited = 0;
		while (sb.pending() > 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (sb.pending() > 0) begin
			$display("%0t: %0d expected blocks never arrived", $time, sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
